[rtl/core/tbp_pkg.sv]
// Shared constants and handshake structs for the tournament branch predictor.
`timescale 1ns / 1ps

package tbp_pkg;

  localparam int PC_INDEX_BITS_DEF   = 12;
  localparam int LOCAL_HIST_BITS_DEF = 12;
  localparam int PATH_HIST_BITS_DEF  = 12;
  localparam int COUNTER_BITS_DEF    = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic valid;
    logic is_cond;
    logic taken;
  } tbp_qhead_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } tbp_bctl_t;

endpackage

[rtl/core/tbp_front.sv]
// Front end: accepts branch items, classifies them and holds them in a short queue.
`timescale 1ns / 1ps

module tbp_front import tbp_pkg::*; #(
  parameter int PC_INDEX_BITS = PC_INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              in_branch_addr,
  input  logic                     in_is_cond,
  input  logic                     in_outcome_taken,
  input  tbp_bctl_t                bctl,
  output tbp_qhead_t               qhead,
  output logic [PC_INDEX_BITS-1:0] head_pc
);

  logic [PC_INDEX_BITS-1:0] q_pc_r [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   q_cond_r;
  logic [QUEUE_DEPTH-1:0]   q_taken_r;
  logic [QPTR_BITS-1:0]     wr_ptr_r;
  logic [QPTR_BITS-1:0]     rd_ptr_r;
  logic [QCNT_BITS-1:0]     cnt_r;
  logic                     push;
  logic                     pop;
  logic [QPTR_BITS-1:0]     wr_ptr_nxt;
  logic [QPTR_BITS-1:0]     rd_ptr_nxt;

  assign in_stall = (cnt_r == QCNT_BITS'(QUEUE_DEPTH)) || bctl.clearing;
  assign push     = in_valid && !in_stall;
  assign pop      = bctl.pop;

  assign wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign qhead.valid   = (cnt_r != '0);
  assign qhead.is_cond = q_cond_r[rd_ptr_r];
  assign qhead.taken   = q_taken_r[rd_ptr_r];
  assign head_pc       = q_pc_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_pc_r[wr_ptr_r]    <= in_branch_addr[PC_INDEX_BITS+1:2];
      q_cond_r[wr_ptr_r]  <= in_is_cond;
      q_taken_r[wr_ptr_r] <= in_outcome_taken;
    end
  end

endmodule

[rtl/core/tbp_back.sv]
// Back end: table lookups, prediction, table update and the result register.
`timescale 1ns / 1ps

module tbp_back import tbp_pkg::*; #(
  parameter int PC_INDEX_BITS   = PC_INDEX_BITS_DEF,
  parameter int LOCAL_HIST_BITS = LOCAL_HIST_BITS_DEF,
  parameter int PATH_HIST_BITS  = PATH_HIST_BITS_DEF,
  parameter int COUNTER_BITS    = COUNTER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tbp_qhead_t               qhead,
  input  logic [PC_INDEX_BITS-1:0] head_pc,
  output tbp_bctl_t                bctl,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_predict_taken,
  output logic                     out_used_local
);

  localparam int LHT_DEPTH = 1 << PC_INDEX_BITS;
  localparam int LCT_DEPTH = 1 << LOCAL_HIST_BITS;
  localparam int GCT_DEPTH = 1 << PATH_HIST_BITS;
  localparam int MAX_A     = (PC_INDEX_BITS > LOCAL_HIST_BITS) ? PC_INDEX_BITS
                                                               : LOCAL_HIST_BITS;
  localparam int CLR_BITS  = (MAX_A > PATH_HIST_BITS) ? MAX_A : PATH_HIST_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LH,
    ST_FIN
  } state_t;

  state_t state_r;

  logic [LOCAL_HIST_BITS-1:0] lht_mem [LHT_DEPTH];
  logic [COUNTER_BITS-1:0]    lct_mem [LCT_DEPTH];
  logic [COUNTER_BITS-1:0]    gct_mem [GCT_DEPTH];
  logic [COUNTER_BITS-1:0]    cht_mem [GCT_DEPTH];

  logic [LOCAL_HIST_BITS-1:0] lht_rd_r;
  logic [COUNTER_BITS-1:0]    lct_rd_r;
  logic [COUNTER_BITS-1:0]    gct_rd_r;
  logic [COUNTER_BITS-1:0]    cht_rd_r;

  logic [CLR_BITS-1:0]        clr_cnt_r;
  logic [PATH_HIST_BITS-1:0]  path_r;
  logic [PC_INDEX_BITS-1:0]   pc_r;
  logic                       taken_r;
  logic                       out_valid_r;
  logic                       out_pred_r;
  logic                       out_local_r;

  logic                       out_free;
  logic                       out_valid_nxt;
  logic                       lpred;
  logic                       gpred;
  logic                       use_local;
  logic                       pred;
  logic [LOCAL_HIST_BITS-1:0] lh_nxt;
  logic [COUNTER_BITS-1:0]    lctr_nxt;
  logic [COUNTER_BITS-1:0]    gctr_nxt;
  logic [COUNTER_BITS-1:0]    ch_nxt;
  logic [PATH_HIST_BITS-1:0]  path_nxt;

  logic                       lookup_re;
  logic                       lct_re;
  logic                       tbl_we;
  logic [PC_INDEX_BITS-1:0]   lht_wa;
  logic [LOCAL_HIST_BITS-1:0] lht_wd;
  logic [LOCAL_HIST_BITS-1:0] lct_wa;
  logic [COUNTER_BITS-1:0]    lct_wd;
  logic [PATH_HIST_BITS-1:0]  gct_wa;
  logic [COUNTER_BITS-1:0]    gct_wd;
  logic [COUNTER_BITS-1:0]    cht_wd;

  assign out_free = !out_valid_r || !out_stall;

  assign lpred     = lct_rd_r[COUNTER_BITS-1];
  assign gpred     = gct_rd_r[COUNTER_BITS-1];
  assign use_local = cht_rd_r[COUNTER_BITS-1];
  assign pred      = use_local ? lpred : gpred;

  assign lh_nxt   = {lht_rd_r[LOCAL_HIST_BITS-2:0], taken_r};
  assign path_nxt = {path_r[PATH_HIST_BITS-2:0], taken_r};

  always_comb begin
    if (taken_r) begin
      lctr_nxt = (&lct_rd_r) ? lct_rd_r : lct_rd_r + 1'b1;
      gctr_nxt = (&gct_rd_r) ? gct_rd_r : gct_rd_r + 1'b1;
    end else begin
      lctr_nxt = (|lct_rd_r) ? lct_rd_r - 1'b1 : lct_rd_r;
      gctr_nxt = (|gct_rd_r) ? gct_rd_r - 1'b1 : gct_rd_r;
    end
  end

  // The chooser moves only when exactly one of the two predictors was right.
  always_comb begin
    ch_nxt = cht_rd_r;
    if (!use_local) begin
      if ((gpred != taken_r) && (lpred == taken_r)) begin
        ch_nxt = cht_rd_r + 1'b1;
      end
    end else if ((gpred == taken_r) && (lpred != taken_r)) begin
      ch_nxt = cht_rd_r - 1'b1;
    end
  end

  assign bctl.clearing = (state_r == ST_CLEAR);
  assign bctl.pop      = (state_r == ST_IDLE) && qhead.valid && (qhead.is_cond || out_free);

  assign lookup_re = (state_r == ST_IDLE) && qhead.valid && qhead.is_cond;
  assign lct_re    = (state_r == ST_LH);

  assign out_valid_nxt = ((state_r == ST_IDLE) && bctl.pop && !qhead.is_cond)
                      || ((state_r == ST_FIN) && out_free)
                      || (out_valid_r && out_stall);

  always_comb begin
    tbl_we = 1'b0;
    lht_wa = pc_r;
    lht_wd = lh_nxt;
    lct_wa = lht_rd_r;
    lct_wd = lctr_nxt;
    gct_wa = path_r;
    gct_wd = gctr_nxt;
    cht_wd = ch_nxt;
    unique case (state_r)
      ST_CLEAR: begin
        tbl_we = 1'b1;
        lht_wa = clr_cnt_r[PC_INDEX_BITS-1:0];
        lht_wd = '0;
        lct_wa = clr_cnt_r[LOCAL_HIST_BITS-1:0];
        lct_wd = '0;
        gct_wa = clr_cnt_r[PATH_HIST_BITS-1:0];
        gct_wd = '0;
        cht_wd = '0;
      end
      ST_FIN: begin
        tbl_we = out_free;
      end
      ST_IDLE, ST_LH: begin
        tbl_we = 1'b0;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      lht_mem[lht_wa] <= lht_wd;
    end
    if (lookup_re) begin
      lht_rd_r <= lht_mem[head_pc];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      lct_mem[lct_wa] <= lct_wd;
    end
    if (lct_re) begin
      lct_rd_r <= lct_mem[lht_rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      gct_mem[gct_wa] <= gct_wd;
    end
    if (lookup_re) begin
      gct_rd_r <= gct_mem[path_r];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      cht_mem[gct_wa] <= cht_wd;
    end
    if (lookup_re) begin
      cht_rd_r <= cht_mem[path_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      path_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (bctl.pop) begin
            if (qhead.is_cond) begin
              pc_r    <= head_pc;
              taken_r <= qhead.taken;
              state_r <= ST_LH;
            end else begin
              out_pred_r  <= 1'b1;
              out_local_r <= 1'b0;
            end
          end
        end
        ST_LH: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_pred_r  <= pred;
            out_local_r <= use_local;
            path_r      <= path_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_pred_r;
  assign out_used_local    = out_local_r;

endmodule

[rtl/core/tournament_branch_predictor.sv]
// Path: an unconditional item goes from the queue straight to the result register; a conditional
// one reads the local history, global counter and chooser tables, then the local counter table.
// Throughput: one unconditional item per cycle while out_stall is low; no new item is taken while
// a conditional one is in the back end, set by the dependent local history and counter reads.
// After reset a counter clears the four tables over 2**max(index widths) addresses (4096 by
// default), during which in_stall stays high and no item is accepted.
`timescale 1ns / 1ps

module tournament_branch_predictor import tbp_pkg::*; #(
  parameter int PC_INDEX_BITS   = PC_INDEX_BITS_DEF,
  parameter int LOCAL_HIST_BITS = LOCAL_HIST_BITS_DEF,
  parameter int PATH_HIST_BITS  = PATH_HIST_BITS_DEF,
  parameter int COUNTER_BITS    = COUNTER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_branch_addr,
  input  logic        in_is_cond,
  input  logic        in_outcome_taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_predict_taken,
  output logic        out_used_local
);

  tbp_qhead_t               qhead;
  tbp_bctl_t                bctl;
  logic [PC_INDEX_BITS-1:0] head_pc;

  tbp_front #(
    .PC_INDEX_BITS(PC_INDEX_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_branch_addr  (in_branch_addr),
    .in_is_cond      (in_is_cond),
    .in_outcome_taken(in_outcome_taken),
    .bctl            (bctl),
    .qhead           (qhead),
    .head_pc         (head_pc)
  );

  tbp_back #(
    .PC_INDEX_BITS  (PC_INDEX_BITS),
    .LOCAL_HIST_BITS(LOCAL_HIST_BITS),
    .PATH_HIST_BITS (PATH_HIST_BITS),
    .COUNTER_BITS   (COUNTER_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .qhead            (qhead),
    .head_pc          (head_pc),
    .bctl             (bctl),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_predict_taken(out_predict_taken),
    .out_used_local   (out_used_local)
  );

endmodule

[rtl/core/tbp_checker.sv]
// Port-level checker for the tournament branch predictor and its bind statement.
`timescale 1ns / 1ps

module tbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] in_branch_addr,
  input logic        in_is_cond,
  input logic        in_outcome_taken,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_predict_taken,
  input logic        out_used_local
);

  // A stalled input item holds its value.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_branch_addr) && $stable(in_is_cond)
                             && $stable(in_outcome_taken))
    else $error("Stalled input item changed.");

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_predict_taken)
                               && $stable(out_used_local))
    else $error("Stalled result item changed.");

  // The table clearing pass starts right after reset and blocks input items.
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("Input not stalled after reset.");

  a_reset_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result item present after reset.");

  // Clearing is still under way just after reset, so no item can be taken or produced then.
  a_clear_hold: assert property (@(posedge clk)
    !rst_n ##1 rst_n |=> in_stall && !out_valid)
    else $error("Clearing pass ended too early.");

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (.*);
